FILE: hdl/assert_macros.svh
// Assertion macros shared by the pending pair match table RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold at every clock edge outside reset.
`define PPMT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Implication checked at every clock edge outside reset.
`define PPMT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ppmt_pkg.sv
// Package for the pending pair match table: sizes, codes and record types.
// No dependencies; imported by the hash unit and the top level.
`default_nettype none

package ppmt_pkg;

   // Table geometry and scan limits.
   localparam int TABLE_BITS  = 10;
   localparam int TSIZE       = 1 << TABLE_BITS;
   localparam int CNT_BITS    = TABLE_BITS + 1;
   localparam int MAX_EXPIRE  = 16;
   localparam int RPT_BITS    = $clog2(MAX_EXPIRE + 1);
   localparam int XB_BITS     = (MAX_EXPIRE > 1) ? $clog2(MAX_EXPIRE) : 1;
   localparam int SCAN_LIMIT  = 4096;
   localparam int SCAN_BITS   = $clog2(SCAN_LIMIT + 1);
   localparam int WINDOW_BITS = 42;

   // Register defaults and the capture length used when snap_len is zero.
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(5000);
   localparam logic [15:0] SNAP_RESET    = 16'd128;
   localparam logic [15:0] SNAP_ZERO_LEN = 16'd64;

   // Finalizer constants.
   localparam logic [63:0] HASH_C1    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] HASH_C2    = 64'hc4ceb9fe1a85ec53;
   localparam int          HASH_SHIFT = 33;

   // Operation codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;
   localparam logic [1:0] OP_ACK    = 2'd3;

   // Register indexes.
   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_SNAP   = 1'b1;

   typedef enum logic [2:0] {
      ST_NEW, ST_REFRESHED, ST_FULL, ST_MATCHED,
      ST_NOT_FOUND, ST_EXPIRED, ST_SCAN_DONE, ST_ACKED
   } status_type;

   // One table slot.
   typedef struct packed {
      logic [63:0]           key;
      logic [63:0]           tstamp;
      logic [15:0]           cap;
      logic [15:0]           wlen;
      logic [7:0]            port;
      logic [TABLE_BITS-1:0] slab;
   } entry_type;

   // One queue reference: valid bit above a slot number.
   typedef struct packed {
      logic                  valid;
      logic [TABLE_BITS-1:0] slot;
   } fifo_ref_type;

   // One buffered expiry report.
   typedef struct packed {
      entry_type             ent;
      logic [TABLE_BITS-1:0] slot;
   } xrec_type;

   // Result word fields apart from last and live count.
   typedef struct packed {
      status_type            status;
      logic [63:0]           key;
      logic [63:0]           tstamp;
      logic [TABLE_BITS-1:0] slot;
      logic [TABLE_BITS-1:0] slab;
      logic [15:0]           cap;
      logic [15:0]           wlen;
      logic [7:0]            port;
      logic [CNT_BITS-1:0]   acked;
      logic                  ovf;
   } res_type;

endpackage

`default_nettype wire

FILE: hdl/pending_pair_match_table.sv
// Pending pair match table: hash table of first copies with an arrival queue.
// Depends on ppmt_pkg, ppmt_ram, ppmt_hash and assert_macros.svh.
//
// Usage:
//   Request words enter on req_* (valid/stall) and result words leave on
//   rsp_* (valid/stall); rsp_last marks the final word of a request. The
//   window and snap length registers are to be written on csr_* while idle;
//   the block itself does not enforce this. One request is worked at a time;
//   req_stall is low only when the sequencer is idle, which may be while a
//   finished word still waits in the output register.
//   Insert and remove pass from acceptance to the result word through the
//   shared-multiplier hash unit, then one table read and one check per probed
//   slot, then the output register. A zero key skips the hash and the probe.
//   An expire scan reads the queue reference of each head visited and, for a
//   valid one, checks the table entry; it then emits each report word and a
//   scan done word. An acknowledge pops each head and clears the live table
//   entry that a valid reference points at. The table read port is registered.
//   After reset a clearing pass zeroes all 1024 entries of the table and queue
//   memories; req_stall stays high meanwhile, register writes still work.
//   When rsp_stall is high while rsp_valid is set, the output word holds and
//   the sequencer waits before emitting its next word.
`default_nettype none
`include "assert_macros.svh"

module pending_pair_match_table import ppmt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_opcode,
   input  logic [63:0]             req_key,
   input  logic [63:0]             req_time_ns,
   input  logic [15:0]             req_cap_len,
   input  logic [15:0]             req_wire_len,
   input  logic [7:0]              req_rx_port,
   input  logic [15:0]             req_ack_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last,
   output logic [63:0]             rsp_entry_key,
   output logic [63:0]             rsp_entry_time,
   output logic [TABLE_BITS-1:0]   rsp_slot,
   output logic [TABLE_BITS-1:0]   rsp_slab_index,
   output logic [15:0]             rsp_entry_cap_len,
   output logic [15:0]             rsp_entry_wire_len,
   output logic [7:0]              rsp_entry_port,
   output logic [CNT_BITS-1:0]     rsp_live_count,
   output logic [CNT_BITS-1:0]     rsp_acked_count,
   output logic                    rsp_queue_overflow,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [WINDOW_BITS-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_PRD, S_PCHK, S_OUT,
      S_XHEAD, S_XREF, S_XCHK, S_XDRN, S_XEMIT, S_XDONE,
      S_AHEAD, S_AREF, S_ACHK
   } state_type;

   localparam logic [TABLE_BITS-1:0] TMASK = {TABLE_BITS{1'b1}};

   state_type                state_ff, state_in;
   logic [TABLE_BITS-1:0]    clr_idx_ff, clr_idx_in;
   logic [WINDOW_BITS-1:0]   window_ff, window_in;
   logic [15:0]              snap_ff, snap_in;
   logic [1:0]               op_ff, op_in;
   logic [63:0]              key_ff, key_in;
   logic [63:0]              time_ff, time_in;
   logic [15:0]              copy_ff, copy_in;
   logic [15:0]              wire_ff, wire_in;
   logic [7:0]               port_ff, port_in;
   logic [15:0]              ack_left_ff, ack_left_in;
   logic [TABLE_BITS-1:0]    probe_ff, probe_in;
   logic [TABLE_BITS-1:0]    pcnt_ff, pcnt_in;
   logic [TABLE_BITS-1:0]    fifo_head_ff, fifo_head_in;
   logic [TABLE_BITS-1:0]    fifo_tail_ff, fifo_tail_in;
   logic [CNT_BITS-1:0]      fifo_count_ff, fifo_count_in;
   logic [TABLE_BITS-1:0]    slab_head_ff, slab_head_in;
   logic [CNT_BITS-1:0]      live_ff, live_in;
   logic [SCAN_BITS-1:0]     scan_n_ff, scan_n_in;
   logic [RPT_BITS-1:0]      rpt_ff, rpt_in;
   logic [RPT_BITS-1:0]      drain_ff, drain_in;
   logic [CNT_BITS-1:0]      popped_ff, popped_in;
   logic [TABLE_BITS-1:0]    ref_slot_ff, ref_slot_in;
   res_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   res_type                  out_ff, out_in;
   logic                     out_last_ff, out_last_in;
   logic [CNT_BITS-1:0]      out_live_ff, out_live_in;

   // Memory ports.
   logic                     tbl_we;
   logic [TABLE_BITS-1:0]    tbl_waddr;
   entry_type                tbl_wdata;
   logic [TABLE_BITS-1:0]    tbl_raddr;
   entry_type                tbl_rdata;
   logic                     fifo_we;
   logic [TABLE_BITS-1:0]    fifo_waddr;
   fifo_ref_type             fifo_wdata;
   fifo_ref_type             fifo_rdata;
   logic                     xb_we;
   xrec_type                 xb_wdata;
   xrec_type                 xb_rdata;

   logic                     hash_start;
   logic                     hash_done;
   logic [TABLE_BITS-1:0]    hash_home;

   logic                     accept;
   logic                     out_free;
   logic [15:0]              eff_snap;
   logic [15:0]              req_copy;
   logic [63:0]              age;
   logic                     older;
   entry_type                ent_new;
   entry_type                ent_clr;
   xrec_type                 xrec;

   ppmt_ram #(.WIDTH($bits(entry_type)), .DEPTH(TSIZE)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   ppmt_ram #(.WIDTH($bits(fifo_ref_type)), .DEPTH(TSIZE)) u_fifo (
      .clock (clock),
      .we    (fifo_we),
      .waddr (fifo_waddr),
      .wdata (fifo_wdata),
      .raddr (fifo_head_ff),
      .rdata (fifo_rdata)
   );

   ppmt_ram #(.WIDTH($bits(xrec_type)), .DEPTH(MAX_EXPIRE)) u_xbuf (
      .clock (clock),
      .we    (xb_we),
      .waddr (rpt_ff[XB_BITS-1:0]),
      .wdata (xb_wdata),
      .raddr (drain_ff[XB_BITS-1:0]),
      .rdata (xb_rdata)
   );

   ppmt_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   // Handshake and shared datapath terms.
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      eff_snap  = (snap_ff == 16'd0) ? SNAP_ZERO_LEN : snap_ff;
      req_copy  = (req_cap_len < eff_snap) ? req_cap_len : eff_snap;
      age       = time_ff - tbl_rdata.tstamp;
      older     = (time_ff > tbl_rdata.tstamp) &&
                  (age > {{(64 - WINDOW_BITS){1'b0}}, window_ff});

      // Fresh entry for an insert into a free slot.
      ent_new.key    = key_ff;
      ent_new.tstamp = time_ff;
      ent_new.cap    = copy_ff;
      ent_new.wlen   = wire_ff;
      ent_new.port   = port_ff;
      ent_new.slab   = slab_head_ff;

      // Cleared version of the entry just read; the slab index is kept.
      ent_clr        = tbl_rdata;
      ent_clr.key    = 64'd0;
      ent_clr.tstamp = 64'd0;
      ent_clr.cap    = 16'd0;
      ent_clr.wlen   = 16'd0;
      ent_clr.port   = 8'd0;

      // Expiry report with the capture length clamped to the snap length (zero too).
      xrec.ent  = tbl_rdata;
      xrec.slot = ref_slot_ff;
      if ((tbl_rdata.cap == 16'd0) || (tbl_rdata.cap > eff_snap)) begin
         xrec.ent.cap = eff_snap;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      window_in     = window_ff;
      snap_in       = snap_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      time_in       = time_ff;
      copy_in       = copy_ff;
      wire_in       = wire_ff;
      port_in       = port_ff;
      ack_left_in   = ack_left_ff;
      probe_in      = probe_ff;
      pcnt_in       = pcnt_ff;
      fifo_head_in  = fifo_head_ff;
      fifo_tail_in  = fifo_tail_ff;
      fifo_count_in = fifo_count_ff;
      slab_head_in  = slab_head_ff;
      live_in       = live_ff;
      scan_n_in     = scan_n_ff;
      rpt_in        = rpt_ff;
      drain_in      = drain_ff;
      popped_in     = popped_ff;
      ref_slot_in   = ref_slot_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_live_in   = out_live_ff;

      tbl_we     = 1'b0;
      tbl_waddr  = probe_ff;
      tbl_wdata  = ent_new;
      tbl_raddr  = probe_ff;
      fifo_we    = 1'b0;
      fifo_waddr = fifo_head_ff;
      fifo_wdata = '0;
      xb_we      = 1'b0;
      xb_wdata   = xrec;
      hash_start = 1'b0;

      // Register writes are taken in any state.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW: window_in = csr_wdata;
            CSR_SNAP:   snap_in   = csr_wdata[15:0];
            default:    ;
         endcase
      end

      case (state_ff)
         // Zero the table and queue ring one entry per cycle after reset.
         S_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = clr_idx_ff;
            tbl_wdata  = '0;
            fifo_we    = 1'b1;
            fifo_waddr = clr_idx_ff;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == TMASK) begin
               state_in = S_IDLE;
            end
         end

         // Take a request word and pick the operation.
         S_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               key_in      = req_key;
               time_in     = req_time_ns;
               copy_in     = req_copy;
               wire_in     = req_wire_len;
               port_in     = req_rx_port;
               ack_left_in = req_ack_count;
               scan_n_in   = '0;
               rpt_in      = '0;
               drain_in    = '0;
               popped_in   = '0;
               res_in      = '0;
               case (req_opcode)
                  OP_INSERT, OP_REMOVE: begin
                     if (req_key == 64'd0) begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_OUT;
                     end else begin
                        res_in.status = (req_opcode == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        hash_start    = 1'b1;
                        state_in      = S_HASH;
                     end
                  end
                  OP_EXPIRE: state_in = S_XHEAD;
                  default:   state_in = S_AHEAD;
               endcase
            end
         end

         S_HASH: begin
            if (hash_done) begin
               probe_in = hash_home;
               pcnt_in  = '0;
               state_in = S_PRD;
            end
         end

         // Read the probed slot.
         S_PRD: begin
            state_in = S_PCHK;
         end

         // Check the probed slot: free, matching or occupied by another key.
         S_PCHK: begin
            res_in.slot = probe_ff;
            if (tbl_rdata.key == 64'd0) begin
               if (op_ff == OP_INSERT) begin
                  tbl_we       = 1'b1;
                  tbl_wdata    = ent_new;
                  slab_head_in = slab_head_ff + 1'b1;
                  live_in      = live_ff + 1'b1;
                  if (fifo_count_ff == CNT_BITS'(TSIZE)) begin
                     res_in.ovf = 1'b1;
                  end else begin
                     fifo_we          = 1'b1;
                     fifo_waddr       = fifo_tail_ff;
                     fifo_wdata.valid = 1'b1;
                     fifo_wdata.slot  = probe_ff;
                     fifo_tail_in     = fifo_tail_ff + 1'b1;
                     fifo_count_in    = fifo_count_ff + 1'b1;
                  end
                  res_in.status = ST_NEW;
                  res_in.key    = ent_new.key;
                  res_in.tstamp = ent_new.tstamp;
                  res_in.slab   = ent_new.slab;
                  res_in.cap    = ent_new.cap;
                  res_in.wlen   = ent_new.wlen;
                  res_in.port   = ent_new.port;
               end else begin
                  res_in.slot = '0;
               end
               state_in = S_OUT;
            end else if (tbl_rdata.key == key_ff) begin
               res_in.key  = tbl_rdata.key;
               res_in.slab = tbl_rdata.slab;
               if (op_ff == OP_INSERT) begin
                  tbl_we           = 1'b1;
                  tbl_wdata        = tbl_rdata;
                  tbl_wdata.tstamp = time_ff;
                  tbl_wdata.wlen   = wire_ff;
                  tbl_wdata.port   = port_ff;
                  if (copy_ff != 16'd0) begin
                     tbl_wdata.cap = copy_ff;
                  end
                  res_in.status = ST_REFRESHED;
                  res_in.tstamp = time_ff;
                  res_in.cap    = tbl_wdata.cap;
                  res_in.wlen   = wire_ff;
                  res_in.port   = port_ff;
               end else begin
                  tbl_we        = 1'b1;
                  tbl_wdata     = ent_clr;
                  res_in.status = ST_MATCHED;
                  res_in.tstamp = tbl_rdata.tstamp;
                  res_in.cap    = tbl_rdata.cap;
                  res_in.wlen   = tbl_rdata.wlen;
                  res_in.port   = tbl_rdata.port;
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
               end
               state_in = S_OUT;
            end else if (pcnt_ff == TMASK) begin
               // Every slot probed: the prefilled full or not-found status stands.
               res_in.slot = '0;
               state_in    = S_OUT;
            end else begin
               probe_in = probe_ff + 1'b1;
               pcnt_in  = pcnt_ff + 1'b1;
               state_in = S_PRD;
            end
         end

         // Final word of a single-word request.
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_in       = res_ff;
               out_last_in  = 1'b1;
               out_live_in  = live_ff;
               state_in     = S_IDLE;
            end
         end

         // Expire scan: look at the queue head unless the queue is empty or a limit is reached.
         S_XHEAD: begin
            if ((fifo_count_ff == '0) || (scan_n_ff == SCAN_BITS'(SCAN_LIMIT)) ||
                (rpt_ff == RPT_BITS'(MAX_EXPIRE))) begin
               state_in = S_XDRN;
            end else begin
               state_in = S_XREF;
            end
         end

         S_XREF: begin
            if (!fifo_rdata.valid) begin
               fifo_we       = 1'b1;
               fifo_head_in  = fifo_head_ff + 1'b1;
               fifo_count_in = fifo_count_ff - 1'b1;
               scan_n_in     = scan_n_ff + 1'b1;
               state_in      = S_XHEAD;
            end else begin
               tbl_raddr   = fifo_rdata.slot;
               ref_slot_in = fifo_rdata.slot;
               state_in    = S_XCHK;
            end
         end

         S_XCHK: begin
            if ((tbl_rdata.key == 64'd0) || (tbl_rdata.tstamp == 64'd0)) begin
               // Stale reference: drop it without a report.
               fifo_we       = 1'b1;
               fifo_head_in  = fifo_head_ff + 1'b1;
               fifo_count_in = fifo_count_ff - 1'b1;
               scan_n_in     = scan_n_ff + 1'b1;
               state_in      = S_XHEAD;
            end else if (!older) begin
               state_in = S_XDRN;
            end else begin
               xb_we         = 1'b1;
               rpt_in        = rpt_ff + 1'b1;
               tbl_we        = 1'b1;
               tbl_waddr     = ref_slot_ff;
               tbl_wdata     = ent_clr;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
               fifo_we       = 1'b1;
               fifo_head_in  = fifo_head_ff + 1'b1;
               fifo_count_in = fifo_count_ff - 1'b1;
               scan_n_in     = scan_n_ff + 1'b1;
               state_in      = S_XHEAD;
            end
         end

         // Replay the buffered reports now that the final live count is known.
         S_XDRN: begin
            if (drain_ff == rpt_ff) begin
               state_in = S_XDONE;
            end else begin
               state_in = S_XEMIT;
            end
         end

         S_XEMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_in        = '0;
               out_in.status = ST_EXPIRED;
               out_in.key    = xb_rdata.ent.key;
               out_in.tstamp = xb_rdata.ent.tstamp;
               out_in.slot   = xb_rdata.slot;
               out_in.slab   = xb_rdata.ent.slab;
               out_in.cap    = xb_rdata.ent.cap;
               out_in.wlen   = xb_rdata.ent.wlen;
               out_in.port   = xb_rdata.ent.port;
               out_last_in   = 1'b0;
               out_live_in   = live_ff;
               drain_in      = drain_ff + 1'b1;
               state_in      = S_XDRN;
            end
         end

         S_XDONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_in        = '0;
               out_in.status = ST_SCAN_DONE;
               out_last_in   = 1'b1;
               out_live_in   = live_ff;
               state_in      = S_IDLE;
            end
         end

         // Acknowledge: pop heads until the count or the queue runs out.
         S_AHEAD: begin
            if ((ack_left_ff == 16'd0) || (fifo_count_ff == '0)) begin
               res_in.status = ST_ACKED;
               res_in.acked  = popped_ff;
               state_in      = S_OUT;
            end else begin
               state_in = S_AREF;
            end
         end

         S_AREF: begin
            fifo_we       = 1'b1;
            fifo_head_in  = fifo_head_ff + 1'b1;
            fifo_count_in = fifo_count_ff - 1'b1;
            ack_left_in   = ack_left_ff - 1'b1;
            popped_in     = popped_ff + 1'b1;
            if (fifo_rdata.valid) begin
               tbl_raddr   = fifo_rdata.slot;
               ref_slot_in = fifo_rdata.slot;
               state_in    = S_ACHK;
            end else begin
               state_in = S_AHEAD;
            end
         end

         S_ACHK: begin
            if (tbl_rdata.key != 64'd0) begin
               tbl_we    = 1'b1;
               tbl_waddr = ref_slot_ff;
               tbl_wdata = ent_clr;
               if (live_ff != '0) begin
                  live_in = live_ff - 1'b1;
               end
            end
            state_in = S_AHEAD;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         window_ff     <= WINDOW_RESET;
         snap_ff       <= SNAP_RESET;
         fifo_head_ff  <= '0;
         fifo_tail_ff  <= '0;
         fifo_count_ff <= '0;
         slab_head_ff  <= '0;
         live_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         window_ff     <= window_in;
         snap_ff       <= snap_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_tail_ff  <= fifo_tail_in;
         fifo_count_ff <= fifo_count_in;
         slab_head_ff  <= slab_head_in;
         live_ff       <= live_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      time_ff     <= time_in;
      copy_ff     <= copy_in;
      wire_ff     <= wire_in;
      port_ff     <= port_in;
      ack_left_ff <= ack_left_in;
      probe_ff    <= probe_in;
      pcnt_ff     <= pcnt_in;
      scan_n_ff   <= scan_n_in;
      rpt_ff      <= rpt_in;
      drain_ff    <= drain_in;
      popped_ff   <= popped_in;
      ref_slot_ff <= ref_slot_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_live_ff <= out_live_in;
   end

   // Result word outputs.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_last           = out_last_ff;
   assign rsp_entry_key      = out_ff.key;
   assign rsp_entry_time     = out_ff.tstamp;
   assign rsp_slot           = out_ff.slot;
   assign rsp_slab_index     = out_ff.slab;
   assign rsp_entry_cap_len  = out_ff.cap;
   assign rsp_entry_wire_len = out_ff.wlen;
   assign rsp_entry_port     = out_ff.port;
   assign rsp_live_count     = out_live_ff;
   assign rsp_acked_count    = out_ff.acked;
   assign rsp_queue_overflow = out_ff.ovf;

   // Queue pointers stay consistent with the fill count.
   `PPMT_ASSERT(a_ptrs, fifo_tail_ff == fifo_head_ff + fifo_count_ff[TABLE_BITS-1:0], "bad pointers")
   `PPMT_ASSERT(a_fifo_bound, fifo_count_ff <= CNT_BITS'(TSIZE), "queue count above capacity")
   `PPMT_ASSERT(a_live_bound, live_ff <= CNT_BITS'(TSIZE), "live count above table size")
   `PPMT_ASSERT_IMP(a_hash_done, hash_done, state_ff == S_HASH, "hash result outside hash wait")

endmodule

`default_nettype wire

FILE: hdl/ppmt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the table, the queue ring and the report buffer.
`default_nettype none

module ppmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

FILE: hdl/ppmt_hash.sv
// Multi-cycle fingerprint finalizer that yields the home slot of a key.
// Depends on ppmt_pkg; one 32x32 multiplier is reused over three of the four phases per round.
`default_nettype none

module ppmt_hash import ppmt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           key,
   output logic                  done,
   output logic [TABLE_BITS-1:0] home
);

   typedef enum logic {H_IDLE, H_RUN} hstate_type;

   hstate_type  hstate_ff, hstate_in;
   logic [1:0]  phase_ff, phase_in;
   logic        round_ff, round_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] p0_ff, p0_in;
   logic [31:0] m1_ff, m1_in;
   logic [31:0] m2_ff, m2_in;
   logic [63:0] cst;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_out;
   logic [31:0] mid;
   logic [63:0] sum;

   // Operand selection for the shared multiplier; only the low 64 bits matter.
   always_comb begin
      cst     = round_ff ? HASH_C2 : HASH_C1;
      mul_a   = (phase_ff == 2'd2) ? x_ff[63:32] : x_ff[31:0];
      mul_b   = (phase_ff == 2'd1) ? cst[63:32] : cst[31:0];
      mul_out = {32'd0, mul_a} * {32'd0, mul_b};
      mid     = m1_ff + m2_ff;
      sum     = p0_ff + {mid, 32'd0};
   end

   // Phase sequencing: low product, two cross products, then add and xorshift.
   always_comb begin
      hstate_in = hstate_ff;
      phase_in  = phase_ff;
      round_in  = round_ff;
      done_in   = 1'b0;
      x_in      = x_ff;
      p0_in     = p0_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      case (hstate_ff)
         H_IDLE: begin
            if (start) begin
               x_in      = key ^ (key >> HASH_SHIFT);
               phase_in  = 2'd0;
               round_in  = 1'b0;
               hstate_in = H_RUN;
            end
         end
         H_RUN: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd0: p0_in = mul_out;
               2'd1: m1_in = mul_out[31:0];
               2'd2: m2_in = mul_out[31:0];
               default: begin
                  x_in = sum ^ (sum >> HASH_SHIFT);
                  if (round_ff) begin
                     done_in   = 1'b1;
                     hstate_in = H_IDLE;
                  end else begin
                     round_in = 1'b1;
                  end
               end
            endcase
         end
         default: hstate_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hstate_ff <= H_IDLE;
         phase_ff  <= 2'd0;
         round_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         hstate_ff <= hstate_in;
         phase_ff  <= phase_in;
         round_ff  <= round_in;
         done_ff   <= done_in;
      end
      x_ff  <= x_in;
      p0_ff <= p0_in;
      m1_ff <= m1_in;
      m2_ff <= m2_in;
   end

   assign done = done_ff;
   assign home = x_ff[TABLE_BITS-1:0];

endmodule

`default_nettype wire
